/* hdl/lfu_block_cache_policy_top_macros.svh */
// ----------------------------------------------------------------------------
// LFU cache policy assertion macros
// Shared assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LFU_BLOCK_CACHE_POLICY_TOP_MACROS_SVH
`define LFU_BLOCK_CACHE_POLICY_TOP_MACROS_SVH
`ifndef SYNTH
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lfu assert");
`define LFU_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("lfu assert");
`else
`define LFU_ASSERT(lbl, clk, rst_n, prop)
`define LFU_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* hdl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache policy package
// Payload types, constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package lfu_pkg;
    localparam int MaxBlocksDef = 64;
    localparam int CfgW = 7;
    localparam logic [CfgW-1:0] CfgReset = 7'd64;
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
    localparam logic [15:0] TallyMax = 16'hFFFF;

    typedef struct packed {
        logic [31:0] block_number;
        logic        is_write;
        logic        last_of_request;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [5:0]  slot;
        logic        evicted;
        logic        writeback_valid;
        logic [31:0] writeback_block;
        logic [15:0] request_misses;
        logic        end_of_request;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch input, bump stamp, reset scan
        logic rd;        // issue read at scan index
        logic chk_hit;   // compare read data for tag match
        logic chk_vic;   // compare read data for victim
        logic rd_sel;    // issue read of selected slot
        logic commit;    // write selected slot, build result
        logic to_vic;    // restart scan for victim search
        logic take_out;  // output consumed
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit_found;
        logic scan_last;  // scan index is final live/active slot
        logic live_zero;
        logic has_free;
        logic out_full;
    } t_sts;
endpackage

/* hdl/lfu_block_cache_policy_top.sv */
// LFU block cache policy, fully associative with an oldest-stamp tie-break.
// One beat in gives one beat out; a new beat is taken only once the previous
// result has left or leaves in the same cycle. Each slot visit is a read of the
// slot memory followed by a compare. The lookup visits the live slots (stopping
// at a hit); a miss with every active slot taken visits all active slots again
// for the victim; then the chosen slot is read and rewritten. No clearing pass
// is needed: a per-slot valid bit zeroes count, stamp and dirty mark of
// unwritten slots.
// ----------------------------------------------------------------------------
// LFU block cache policy top
// APB register, handshakes and controller/datapath wiring.
// ----------------------------------------------------------------------------
module lfu_block_cache_policy_top #(
    parameter int MaxBlocks = lfu_pkg::MaxBlocksDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lfu_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lfu_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import lfu_pkg::*;

    localparam logic [1:0] RegBlocks = 2'd0;

    logic [CfgW-1:0] r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;
    assign prdata = (paddr == RegBlocks) ? {25'd0, r_cfg} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= CfgReset;
        else if (psel && penable && pwrite && paddr == RegBlocks) r_cfg <= pwdata[CfgW-1:0];
    end

    lfu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_out_take(o_out_valid && !i_out_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    lfu_dp #(.MaxBlocks(MaxBlocks)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_data),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out_data),
        .o_out_valid(o_out_valid)
    );

`include "lfu_block_cache_policy_top_macros.svh"
    `LFU_ASSERT(a_out_hold, i_clk, i_rst_n,
                $past(o_out_valid && i_out_stall) |-> $stable(o_out_data))
    `LFU_ASSERT(a_ready, i_clk, i_rst_n, pready)
    `LFU_ASSERT(a_wb_zero, i_clk, i_rst_n,
                o_out_valid && !o_out_data.writeback_valid
                |-> o_out_data.writeback_block == 32'd0)
endmodule

/* hdl/lfu_ram.sv */
// ----------------------------------------------------------------------------
// LFU generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/lfu_ctrl.sv */
// ----------------------------------------------------------------------------
// LFU controller
// Sequences lookup scan, victim scan and commit of one beat.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_take,
    input  lfu_pkg::t_sts i_sts,
    output lfu_pkg::t_cmd o_cmd
);
    import lfu_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HRD   = 7'b0000010,
        S_HCHK  = 7'b0000100,
        S_VRD   = 7'b0001000,
        S_VCHK  = 7'b0010000,
        S_SEL   = 7'b0100000,
        S_COMM  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept     = (r_state == S_IDLE) && i_in_valid && !i_sts.out_full;
    assign o_in_stall = !((r_state == S_IDLE) && !i_sts.out_full);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.take_out = i_out_take;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                if (i_sts.live_zero) begin
                    n_state = i_sts.has_free ? S_SEL : S_VRD;
                    o_cmd.to_vic = !i_sts.has_free;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_HCHK;
                end
            end
            S_HCHK: begin
                o_cmd.chk_hit = 1'b1;
                if (i_sts.hit_found || i_sts.scan_last) begin
                    if (i_sts.hit_found || i_sts.has_free) begin
                        n_state = S_SEL;
                    end else begin
                        o_cmd.to_vic = 1'b1;
                        n_state = S_VRD;
                    end
                end else begin
                    n_state = S_HRD;
                end
            end
            S_VRD: begin
                o_cmd.rd = 1'b1;
                n_state = S_VCHK;
            end
            S_VCHK: begin
                o_cmd.chk_vic = 1'b1;
                n_state = i_sts.scan_last ? S_SEL : S_VRD;
            end
            S_SEL: begin
                o_cmd.rd_sel = 1'b1;
                n_state = S_COMM;
            end
            S_COMM: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

`include "lfu_block_cache_policy_top_macros.svh"
    `LFU_ASSERT(a_start_idle, i_clk, i_rst_n, o_cmd.start |=> r_state == S_HRD)
    `LFU_ASSERT(a_commit_once, i_clk, i_rst_n, o_cmd.commit |=> r_state == S_IDLE)
    `LFU_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_in_stall)
endmodule

/* hdl/lfu_dp.sv */
// ----------------------------------------------------------------------------
// LFU datapath
// Slot memory and per-slot valid bits, scan index, compare registers and result register.
// ----------------------------------------------------------------------------
module lfu_dp #(
    parameter int MaxBlocks = lfu_pkg::MaxBlocksDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lfu_pkg::t_in          i_in,
    input  logic [lfu_pkg::CfgW-1:0] i_cfg,
    input  lfu_pkg::t_cmd         i_cmd,
    output lfu_pkg::t_sts         o_sts,
    output lfu_pkg::t_out         o_out,
    output logic                  o_out_valid
);
    import lfu_pkg::*;

    localparam int IW = $clog2(MaxBlocks);
    localparam int CW = $clog2(MaxBlocks + 1);
    localparam int XW = (CW > CfgW) ? CW : CfgW;
    localparam int EW = 32 + 1 + 32 + 64; // tag, dirty, count, stamp

    // count/stamp/dirty reset to zero: valid bits per slot
    logic [MaxBlocks-1:0] r_vld;
    logic [CW-1:0] r_alloc, n_alloc_cnt, act, live;
    logic [63:0]   r_stamp;
    logic [15:0]   r_tally;
    t_in           r_in;
    logic [IW-1:0] r_idx, r_ridx, r_sel;
    logic [31:0]   r_bcnt;
    logic [63:0]   r_bstp;
    logic          r_hit, r_evict, r_first;
    logic          r_ovld;
    t_out          r_out;

    logic          we;
    logic [IW-1:0] raddr;
    logic [EW-1:0] wdata, rdata;
    logic [31:0]   rd_tag, rd_cnt;
    logic          rd_dty;
    logic [63:0]   rd_stp;
    logic          rv;
    logic [CW-1:0] scan_end;
    logic [XW-1:0] cfg_x;

    lfu_ram #(.Width(EW), .Depth(MaxBlocks)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_sel),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // active slot count, clamped to 1..MaxBlocks
    always_comb begin
        cfg_x = XW'(i_cfg);
        if (cfg_x == '0)                     act = CW'(1);
        else if (cfg_x > XW'(MaxBlocks))     act = CW'(MaxBlocks);
        else                                 act = CW'(cfg_x);
        live = (r_alloc < act) ? r_alloc : act;
    end

    assign rv     = r_vld[r_ridx];
    assign rd_tag = rdata[EW-1 -: 32];
    assign rd_dty = rv & rdata[96];
    assign rd_cnt = rv ? rdata[95:64] : 32'd0;
    assign rd_stp = rv ? rdata[63:0]  : 64'd0;

    assign raddr = i_cmd.rd_sel ? r_sel : r_idx;
    // victim scan only runs with every active slot allocated, so live == act there
    assign scan_end = live;
    assign n_alloc_cnt = r_alloc + CW'(1);

    always_comb begin
        o_sts.hit_found = 1'b0;
        if (i_cmd.chk_hit && rd_tag == r_in.block_number) o_sts.hit_found = 1'b1;
        o_sts.scan_last = (CW'(r_ridx) == scan_end - CW'(1));
        o_sts.live_zero = (live == '0);
        o_sts.has_free  = (r_alloc < act);
        o_sts.out_full  = r_ovld && !i_cmd.take_out;
    end

    // commit write: new/updated entry
    logic [31:0] new_cnt;
    logic        new_dty;
    always_comb begin
        if (r_hit) begin
            new_cnt = (rd_cnt == CountMax) ? rd_cnt : rd_cnt + 32'd1;
            new_dty = rd_dty | r_in.is_write;
        end else begin
            new_cnt = 32'd1;
            new_dty = r_in.is_write;
        end
        we    = i_cmd.commit;
        wdata = {r_in.block_number, new_dty, new_cnt, r_stamp};
    end

    logic victim_better;
    assign victim_better = (rd_cnt < r_bcnt) || (rd_cnt == r_bcnt && rd_stp < r_bstp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_alloc <= '0;
            r_stamp <= '0;
            r_tally <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cmd.take_out) r_ovld <= 1'b0;
            if (i_cmd.start) begin
                r_in    <= i_in;
                r_stamp <= r_stamp + 64'd1;
                r_idx   <= '0;
                r_hit   <= 1'b0;
                r_evict <= 1'b0;
            end
            if (i_cmd.rd) begin
                r_ridx <= r_idx;
                r_idx  <= r_idx + IW'(1);
            end
            if (o_sts.hit_found) begin
                r_hit <= 1'b1;
                r_sel <= r_ridx;
            end else if (i_cmd.chk_hit && o_sts.scan_last && o_sts.has_free) begin
                r_sel <= r_alloc[IW-1:0];
            end
            if (i_cmd.start) begin
                r_sel <= r_alloc[IW-1:0];
            end
            if (i_cmd.to_vic) begin
                r_idx   <= '0;
                r_ridx  <= '0;
                r_evict <= 1'b1;
                r_first <= 1'b1;
            end
            if (i_cmd.chk_vic) begin
                r_first <= 1'b0;
                if (r_first || victim_better) begin
                    r_bcnt <= rd_cnt;
                    r_bstp <= rd_stp;
                    r_sel  <= r_ridx;
                end
            end
            if (i_cmd.commit) begin
                r_vld[r_sel] <= 1'b1;
                if (!r_hit && !r_evict) r_alloc <= n_alloc_cnt;
                r_ovld <= 1'b1;
                r_out.hit    <= r_hit;
                r_out.slot   <= 6'(r_sel);
                r_out.evicted <= r_evict;
                r_out.writeback_valid <= r_evict & rd_dty;
                r_out.writeback_block <= (r_evict & rd_dty) ? rd_tag : 32'd0;
                r_out.end_of_request  <= r_in.last_of_request;
                if (r_hit) begin
                    r_out.request_misses <= r_tally;
                    if (r_in.last_of_request) r_tally <= '0;
                end else begin
                    r_out.request_misses <= (r_tally == TallyMax) ? r_tally : r_tally + 16'd1;
                    if (r_in.last_of_request) r_tally <= '0;
                    else if (r_tally != TallyMax) r_tally <= r_tally + 16'd1;
                end
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_ovld;

`include "lfu_block_cache_policy_top_macros.svh"
    `LFU_ASSERT(a_alloc_bound, i_clk, i_rst_n, r_alloc <= CW'(MaxBlocks))
    `LFU_ASSERT(a_commit_out, i_clk, i_rst_n, i_cmd.commit |=> r_ovld)
    `LFU_ASSERT(a_hit_no_evict, i_clk, i_rst_n, r_ovld && r_out.hit |-> !r_out.evicted)
endmodule

/* test/lfu_block_cache_policy_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFU block cache policy testbench
// Drives block accesses through the valid/stall channel, changes the active
// slot count over APB between phases, and checks every result beat against a
// local LFU/oldest-stamp cache predictor.
// ----------------------------------------------------------------------------
module lfu_block_cache_policy_top_tb;
    import lfu_pkg::*;

    localparam int NumSlots = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lfu_block_cache_policy_top uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] tags [NumSlots];
    logic        dirty [NumSlots];
    logic [31:0] counts [NumSlots];
    logic [63:0] stamps [NumSlots];
    int unsigned filled;
    logic [63:0] clock_stamp;
    logic [15:0] tally;
    logic [6:0]  slots_reg;

    t_out pending_results [$];
    int   fail_count = 0;
    logic finished_ok = 1'b0;

    // block pool so that hits are frequent
    logic [31:0] pool [16];

    function automatic int unsigned live_slots();
        int unsigned n;
        n = slots_reg;
        if (n == 0) n = 1;
        if (n > NumSlots) n = NumSlots;
        return n;
    endfunction

    function automatic t_out predict_access(t_in beat);
        t_out r;
        int unsigned n, live, best;
        r = '0;
        n = live_slots();
        live = filled < n ? filled : n;
        clock_stamp = clock_stamp + 64'd1;
        for (int i = 0; i < live; i++) begin
            if (!r.hit && tags[i] == beat.block_number) begin
                r.hit = 1'b1;
                r.slot = i[5:0];
            end
        end
        if (r.hit) begin
            if (counts[r.slot] != CountMax) counts[r.slot]++;
            stamps[r.slot] = clock_stamp;
            if (beat.is_write) dirty[r.slot] = 1'b1;
        end else begin
            if (tally != TallyMax) tally++;
            if (filled < n) begin
                best = filled;
                filled++;
            end else begin
                best = 0;
                for (int i = 1; i < n; i++)
                    if (counts[i] < counts[best] ||
                        (counts[i] == counts[best] && stamps[i] < stamps[best]))
                        best = i;
                r.evicted = 1'b1;
                if (dirty[best]) begin
                    r.writeback_valid = 1'b1;
                    r.writeback_block = tags[best];
                end
            end
            r.slot = best[5:0];
            tags[best] = beat.block_number;
            dirty[best] = beat.is_write;
            counts[best] = 32'd1;
            stamps[best] = clock_stamp;
        end
        r.request_misses = tally;
        r.end_of_request = beat.last_of_request;
        if (beat.last_of_request) tally = '0;
        return r;
    endfunction

    // one beat in; prediction made at acceptance; valid stays high until the
    // next beat or the next drain
    task automatic send_access(logic [31:0] blk, logic wr, logic last);
        int unsigned w;
        w = $urandom_range(0, 8);
        @(negedge i_clk);
        if (w != 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        i_in_data <= '{block_number: blk, is_write: wr, last_of_request: last};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_access(i_in_data));
    endtask

    // result stall: random length, drawn anew per beat
    initial begin
        int unsigned w;
        forever begin
            @(negedge i_clk);
            w = $urandom_range(0, 8);
            if (w != 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                t_out e;
                e = pending_results.pop_front();
                if (e.hit != o_out_data.hit) begin
                    $error("hit exp %0d got %0d", e.hit, o_out_data.hit); fail_count++;
                end
                if (e.slot != o_out_data.slot) begin
                    $error("slot exp %0d got %0d", e.slot, o_out_data.slot); fail_count++;
                end
                if (e.evicted != o_out_data.evicted) begin
                    $error("evicted exp %0d got %0d", e.evicted, o_out_data.evicted);
                    fail_count++;
                end
                if (e.writeback_valid != o_out_data.writeback_valid) begin
                    $error("writeback_valid exp %0d got %0d", e.writeback_valid,
                           o_out_data.writeback_valid);
                    fail_count++;
                end
                if (e.writeback_block != o_out_data.writeback_block) begin
                    $error("writeback_block exp %h got %h", e.writeback_block,
                           o_out_data.writeback_block);
                    fail_count++;
                end
                if (e.request_misses != o_out_data.request_misses) begin
                    $error("request_misses exp %0d got %0d", e.request_misses,
                           o_out_data.request_misses);
                    fail_count++;
                end
                if (e.end_of_request != o_out_data.end_of_request) begin
                    $error("end_of_request exp %0d got %0d", e.end_of_request,
                           o_out_data.end_of_request);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB write of the slot count; only with the block idle
    task automatic write_slots(logic [6:0] v);
        drain();
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {25'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        slots_reg = v;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        // field extremes, fills, hits with write, request boundaries
        send_access(32'h0000_0000, 1'b0, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_access(32'h0000_0000, 1'b1, 1'b1);
        send_access(32'hAAAA_5555, 1'b0, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b0, 1'b1);
    endtask

    task automatic test_tiny_cache();
        // one slot (register 0 acts as one): every miss evicts, dirty writeback
        write_slots(7'd0);
        send_access(32'h1234_5678, 1'b1, 1'b0);
        send_access(32'h5555_AAAA, 1'b0, 1'b0);
        send_access(32'h5555_AAAA, 1'b1, 1'b1);
        write_slots(7'd2);
        // ties on count resolved by oldest stamp, clean eviction
        for (int i = 0; i < 8; i++) send_access(32'h100 + i % 3, i[0], i == 7);
    endtask

    task automatic test_register_extremes();
        // above the built size acts as full size; shrinking hides slots
        write_slots(7'd127);
        for (int i = 0; i < 70; i++) send_access(32'h2000 + i, i[1], i % 10 == 9);
        write_slots(7'd3);
        for (int i = 0; i < 10; i++) send_access(32'h2000 + i % 5, 1'b0, 1'b1);
        write_slots(7'd64);
        send_access(32'h2000 + 40, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [6:0] sizes [5] = '{7'd1, 7'd4, 7'd16, 7'd64, 7'd9};
        for (int i = 0; i < 16; i++) pool[i] = $urandom;
        for (int ph = 0; ph < 5; ph++) begin
            write_slots(sizes[ph]);
            for (int k = 0; k < 110; k++) begin
                logic [31:0] blk;
                if ($urandom_range(0, 3) != 0)
                    blk = pool[$urandom_range(0, (sizes[ph] > 12) ? 15 : 6)];
                else
                    blk = $urandom;
                send_access(blk, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NumSlots; i++) begin
            tags[i] = '0; dirty[i] = 1'b0; counts[i] = '0; stamps[i] = '0;
        end
        filled = 0; clock_stamp = '0; tally = '0; slots_reg = CfgReset;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_tiny_cache();
        test_register_extremes();
        test_random_traffic();
        drain();
        finished_ok = 1'b1;
        if (fail_count == 0)
            $display("lfu_block_cache_policy_top regression: pass");
        else
            $display("lfu_block_cache_policy_top regression: fail");
        $finish;
    end

    // ~650 items with stalls; generous ceiling
    initial begin
        #20ms;
        if (!finished_ok) $display("lfu_block_cache_policy_top regression: fail");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_ram.sv
hdl/lfu_ctrl.sv
hdl/lfu_dp.sv
hdl/lfu_block_cache_policy_top.sv
test/lfu_block_cache_policy_top_tb.sv
